[hdl/rvr_pkg.sv]
// rvr_pkg: shared types, constants and helper functions of the vector rotator
// no dependencies; used by the interfaces and every rotator module
package rvr_pkg;

	localparam int WORD_W            = 32;
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int SQRT_STEPS        = 32;
	localparam int QUO_BITS          = 31;
	localparam int NUM_W             = 62;

	// cordic start value, pre-scaled by the inverse gain, q2.30
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	// arctangent of 2^-i as a binary angle
	localparam logic signed [31:0] ATAN_TAB [0:31] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5339221,
		32'sd2669139, 32'sd1334575, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1, 32'sd1, 32'sd0
	};

	// configuration register map
	typedef enum logic [2:0] {
		REG_ANGLE_PER_ITEM = 3'd0,
		REG_AXIS_PER_ITEM  = 3'd1,
		REG_SHARED_ANGLE   = 3'd2,
		REG_SHARED_AXIS_X  = 3'd3,
		REG_SHARED_AXIS_Y  = 3'd4,
		REG_SHARED_AXIS_Z  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic        [31:0] angle;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic               last_in;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               last_out;
		logic               zero_axis;
	} out_word_t;

	// register contents seen by the datapath
	typedef struct packed {
		logic              angle_per_item;
		logic              axis_per_item;
		logic [31:0]       shared_angle;
		logic [2:0][31:0]  shared_axis;
	} cfg_state_t;

	// everything an item carries down the pipeline
	typedef struct packed {
		logic [2:0][31:0] v;
		logic [31:0]      ang;
		logic             last;
		logic             zero;
		logic [2:0]       neg;
		logic [2:0][31:0] bmag;
		logic [63:0]      norm2;
		logic [31:0]      cos_v;
		logic [31:0]      sin_v;
		logic [2:0][30:0] umag;
	} item_t;

	// round to nearest, halves away from zero, then shift right
	function automatic logic signed [71:0] round_off(input logic signed [71:0] val,
		input logic [6:0] sh);
		logic [71:0] m;
		logic [71:0] r;
		m = val[71] ? 72'(-val) : 72'(val);
		r = (m + (72'd1 << (sh - 7'd1))) >> sh;
		return val[71] ? -$signed(r) : $signed(r);
	endfunction

endpackage

[hdl/rvr_if.sv]
// rvr_if: valid/ready channels of the vector rotator (input, result, config)
// depends on rvr_pkg for the word types
interface rvr_in_if;
	logic             valid;
	logic             ready;
	rvr_pkg::in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rvr_out_if;
	logic               valid;
	logic               ready;
	rvr_pkg::out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rvr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[hdl/rvr_front.sv]
// rvr_front: operand select, axis magnitude, normalizing shift and squared norm
// depends on rvr_pkg; six pipeline stages
module rvr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  rvr_pkg::in_word_t   word,
	input  rvr_pkg::cfg_state_t cfgs,
	output logic                vld_out,
	output rvr_pkg::item_t      item_out
);
	import rvr_pkg::*;

	logic [2:0][31:0] axis_sel;
	logic [2:0][31:0] amag_new;
	item_t            item_new;
	logic [31:0]      m01;
	logic [31:0]      m_new;
	logic [2:0][31:0] bmag_new;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	logic [2:0][31:0] amag_s1, amag_s2, amag_s3;
	logic [31:0]      m_s2;
	logic [4:0]       sh_s3;
	logic [2:0][63:0] sq_s5;

	// leading zeros of a 31-bit magnitude
	function automatic logic [4:0] lead_zeros(input logic [30:0] m);
		logic [4:0] n;
		logic       found;
		n = '0;
		found = 1'b0;
		for (int b = 30; b >= 0; b--) begin
			if (!found) begin
				if (m[b]) found = 1'b1;
				else n = n + 5'd1;
			end
		end
		return n;
	endfunction

	// select angle and axis, take magnitudes
	always_comb begin
		axis_sel[0] = cfgs.axis_per_item ? word.axis_x : cfgs.shared_axis[0];
		axis_sel[1] = cfgs.axis_per_item ? word.axis_y : cfgs.shared_axis[1];
		axis_sel[2] = cfgs.axis_per_item ? word.axis_z : cfgs.shared_axis[2];
		item_new = '0;
		item_new.v[0] = word.vec_x;
		item_new.v[1] = word.vec_y;
		item_new.v[2] = word.vec_z;
		item_new.ang = cfgs.angle_per_item ? word.angle : cfgs.shared_angle;
		item_new.last = word.last_in;
		for (int j = 0; j < 3; j++) begin
			item_new.neg[j] = axis_sel[j][31];
			amag_new[j] = axis_sel[j][31] ? 32'(-axis_sel[j]) : axis_sel[j];
		end
	end

	// largest component
	always_comb begin
		m01 = (amag_s1[0] > amag_s1[1]) ? amag_s1[0] : amag_s1[1];
		m_new = (m01 > amag_s1[2]) ? m01 : amag_s1[2];
	end

	// scaled axis
	always_comb begin
		for (int j = 0; j < 3; j++) bmag_new[j] = amag_s3[j] << sh_s3;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= item_new;
			amag_s1 <= amag_new;

			it_s2 <= it_s1;
			amag_s2 <= amag_s1;
			m_s2 <= m_new;

			it_s3 <= it_s2;
			it_s3.zero <= (m_s2 == '0);
			amag_s3 <= amag_s2;
			sh_s3 <= m_s2[31] ? 5'd0 : lead_zeros(m_s2[30:0]);

			it_s4 <= it_s3;
			it_s4.bmag <= bmag_new;

			it_s5 <= it_s4;
			for (int j = 0; j < 3; j++) sq_s5[j] <= 64'(it_s4.bmag[j]) * 64'(it_s4.bmag[j]);

			it_s6 <= it_s5;
			it_s6.norm2 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
		end
	end

	assign vld_out = vld_s6;
	assign item_out = it_s6;

endmodule

[hdl/rvr_cordic.sv]
// rvr_cordic: pipelined sine/cosine of the binary angle, one rotation per stage
// depends on rvr_pkg; STAGES + 2 pipeline stages
module rvr_cordic #(
	parameter int STAGES = rvr_pkg::CORDIC_STAGES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  rvr_pkg::item_t item_in,
	output logic           vld_out,
	output rvr_pkg::item_t item_out
);
	import rvr_pkg::*;

	logic [31:0]        turn;
	logic               vld_s [STAGES+1];
	item_t              item_s [STAGES+1];
	logic signed [32:0] x_s [STAGES+1];
	logic signed [32:0] y_s [STAGES+1];
	logic signed [31:0] z_s [STAGES+1];
	logic [1:0]         q_s [STAGES+1];
	logic signed [31:0] cx, cy, c_new, s_new;
	logic               vld_map_s;
	item_t              item_map_s;

	function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] val);
		if (val > 33'sd1073741824) return 32'sd1073741824;
		else if (val < -33'sd1073741824) return -32'sd1073741824;
		else return $signed(val[31:0]);
	endfunction

	// shift by an eighth turn so the quadrant sits in the top bits
	assign turn = item_in.ang + 32'h2000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s[0] <= item_in;
			x_s[0] <= CORDIC_GAIN;
			y_s[0] <= '0;
			z_s[0] <= $signed({2'b00, turn[29:0]}) - 32'sd536870912;
			q_s[0] <= turn[31:30];
		end
	end

	// rotation stages
	for (genvar i = 0; i < STAGES; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else if (en) vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_s[i+1] <= item_s[i];
				q_s[i+1] <= q_s[i];
				if (!z_s[i][31]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end
			end
		end
	end

	// clamp and map back by quadrant
	always_comb begin
		cx = clamp_unit(x_s[STAGES]);
		cy = clamp_unit(y_s[STAGES]);
		case (q_s[STAGES])
			2'd0: begin
				c_new = cx;
				s_new = cy;
			end
			2'd1: begin
				c_new = -cy;
				s_new = cx;
			end
			2'd2: begin
				c_new = -cx;
				s_new = -cy;
			end
			default: begin
				c_new = cy;
				s_new = -cx;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_map_s <= 1'b0;
		else if (en) vld_map_s <= vld_s[STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_map_s <= item_s[STAGES];
			item_map_s.cos_v <= c_new;
			item_map_s.sin_v <= s_new;
		end
	end

	assign vld_out = vld_map_s;
	assign item_out = item_map_s;

endmodule

[hdl/rvr_norm.sv]
// rvr_norm: unit axis by pipelined integer square root and restoring division
// depends on rvr_pkg; SQRT_STEPS + QUO_BITS + 2 pipeline stages
module rvr_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  rvr_pkg::item_t item_in,
	output logic           vld_out,
	output rvr_pkg::item_t item_out
);
	import rvr_pkg::*;

	logic        vld_r [SQRT_STEPS+1];
	item_t       item_r [SQRT_STEPS+1];
	logic [63:0] rem_r [SQRT_STEPS+1];
	logic [63:0] root_r [SQRT_STEPS+1];

	logic                      vld_d [QUO_BITS+1];
	item_t                     item_d [QUO_BITS+1];
	logic [31:0]               div_d [QUO_BITS+1];
	logic [2:0][NUM_W-1:0]     num_d [QUO_BITS+1];
	logic [2:0][31:0]          part_d [QUO_BITS+1];
	logic [2:0][QUO_BITS-1:0]  quo_d [QUO_BITS+1];

	logic [31:0]           nrm;
	logic [2:0][NUM_W-1:0] num_new;

	// square root input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_r[0] <= 1'b0;
		else if (en) vld_r[0] <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_r[0] <= item_in;
			rem_r[0] <= item_in.norm2;
			root_r[0] <= '0;
		end
	end

	// one result bit per stage
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic [64:0] trial;
		assign trial = {1'b0, root_r[i]} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_r[i+1] <= 1'b0;
			else if (en) vld_r[i+1] <= vld_r[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_r[i+1] <= item_r[i];
				if ({1'b0, rem_r[i]} >= trial) begin
					rem_r[i+1] <= rem_r[i] - trial[63:0];
					root_r[i+1] <= (root_r[i] >> 1) + BIT;
				end else begin
					rem_r[i+1] <= rem_r[i];
					root_r[i+1] <= root_r[i] >> 1;
				end
			end
		end
	end

	// rounded dividend: scaled axis times 2^30 plus half the norm
	assign nrm = root_r[SQRT_STEPS][31:0];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			num_new[j] = {item_r[SQRT_STEPS].bmag[j], 30'd0} + NUM_W'(nrm >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_d[0] <= 1'b0;
		else if (en) vld_d[0] <= vld_r[SQRT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_d[0] <= item_r[SQRT_STEPS];
			div_d[0] <= nrm;
			num_d[0] <= num_new;
			for (int j = 0; j < 3; j++) begin
				part_d[0][j] <= {1'b0, num_new[j][NUM_W-1:QUO_BITS]};
			end
			quo_d[0] <= '0;
		end
	end

	// one quotient bit per stage, three lanes
	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		localparam int B = QUO_BITS - 1 - k;
		logic [2:0][32:0] trial;
		always_comb begin
			for (int j = 0; j < 3; j++) trial[j] = {part_d[k][j], num_d[k][j][B]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[k+1] <= 1'b0;
			else if (en) vld_d[k+1] <= vld_d[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				item_d[k+1] <= item_d[k];
				div_d[k+1] <= div_d[k];
				num_d[k+1] <= num_d[k];
				for (int j = 0; j < 3; j++) begin
					if (trial[j] >= {1'b0, div_d[k]}) begin
						part_d[k+1][j] <= 32'(trial[j] - {1'b0, div_d[k]});
						quo_d[k+1][j] <= {quo_d[k][j][QUO_BITS-2:0], 1'b1};
					end else begin
						part_d[k+1][j] <= trial[j][31:0];
						quo_d[k+1][j] <= {quo_d[k][j][QUO_BITS-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_comb begin
		item_out = item_d[QUO_BITS];
		item_out.umag = quo_d[QUO_BITS];
	end
	assign vld_out = vld_d[QUO_BITS];

endmodule

[hdl/rvr_back.sv]
// rvr_back: cross/dot products, rodrigues terms, rounding and saturation
// depends on rvr_pkg; nine pipeline stages, the last is the result register
module rvr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_in,
	input  rvr_pkg::item_t     item_in,
	output logic               vld_out,
	output rvr_pkg::out_word_t word_out
);
	import rvr_pkg::*;

	logic signed [31:0] u_new [3];
	logic signed [31:0] v_in [3];
	logic signed [32:0] omc;
	logic signed [71:0] fin [3];
	logic signed [31:0] sat [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8;
	logic signed [31:0] u_s1 [3], u_s2 [3], u_s3 [3], u_s4 [3], u_s5 [3];
	logic signed [63:0] crs_a_s1 [3], crs_b_s1 [3], dot_s1 [3], cv_s1 [3];
	logic signed [64:0] dif_s2 [3];
	logic signed [65:0] dsum_s2;
	logic signed [36:0] t1_s2 [3], t1_s3 [3], t1_s4 [3], t1_s5 [3], t1_s6 [3];
	logic signed [33:0] w16_s3 [3];
	logic signed [34:0] p16_s3;
	logic signed [67:0] kprod_s4;
	logic signed [65:0] swp_s4 [3];
	logic signed [36:0] k_s5;
	logic signed [37:0] t2_s5 [3], t2_s6 [3];
	logic signed [68:0] ku_s6 [3];
	logic signed [39:0] t3_s7 [3];
	logic signed [38:0] t12_s7 [3];
	logic signed [41:0] sum_s8 [3];
	out_word_t          word_s9;

	// signed unit axis and vector
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			u_new[j] = item_in.neg[j] ? -$signed({1'b0, item_in.umag[j]})
				: $signed({1'b0, item_in.umag[j]});
			v_in[j] = $signed(item_in.v[j]);
		end
	end

	// one minus cosine
	assign omc = 33'sd1073741824 - 33'($signed(it_s3.cos_v));

	// final rounding and saturation
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			fin[j] = round_off(72'(sum_s8[j]), 7'd4);
			if (fin[j] > 72'sd2147483647) sat[j] = 32'sh7fff_ffff;
			else if (fin[j] < -72'sd2147483648) sat[j] = 32'sh8000_0000;
			else sat[j] = fin[j][31:0];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// products
			it_s1 <= item_in;
			for (int j = 0; j < 3; j++) begin
				u_s1[j] <= u_new[j];
				crs_a_s1[j] <= 64'(u_new[(j+1)%3]) * 64'(v_in[(j+2)%3]);
				crs_b_s1[j] <= 64'(u_new[(j+2)%3]) * 64'(v_in[(j+1)%3]);
				dot_s1[j] <= 64'(u_new[j]) * 64'(v_in[j]);
				cv_s1[j] <= 64'($signed(item_in.cos_v)) * 64'(v_in[j]);
			end

			// cross differences, dot sum, cosine term
			it_s2 <= it_s1;
			u_s2 <= u_s1;
			dsum_s2 <= 66'(dot_s1[0]) + 66'(dot_s1[1]) + 66'(dot_s1[2]);
			for (int j = 0; j < 3; j++) begin
				dif_s2[j] <= 65'(crs_a_s1[j]) - 65'(crs_b_s1[j]);
				t1_s2[j] <= 37'(round_off(72'(cv_s1[j]), 7'd26));
			end

			// back to q16
			it_s3 <= it_s2;
			u_s3 <= u_s2;
			t1_s3 <= t1_s2;
			p16_s3 <= 35'(round_off(72'(dsum_s2), 7'd30));
			for (int j = 0; j < 3; j++) w16_s3[j] <= 34'(round_off(72'(dif_s2[j]), 7'd30));

			// (1 - c) * projection, s * cross
			it_s4 <= it_s3;
			u_s4 <= u_s3;
			t1_s4 <= t1_s3;
			kprod_s4 <= 68'(omc) * 68'(p16_s3);
			for (int j = 0; j < 3; j++) swp_s4[j] <= 66'($signed(it_s3.sin_v)) * 66'(w16_s3[j]);

			it_s5 <= it_s4;
			u_s5 <= u_s4;
			t1_s5 <= t1_s4;
			k_s5 <= 37'(round_off(72'(kprod_s4), 7'd30));
			for (int j = 0; j < 3; j++) t2_s5[j] <= 38'(round_off(72'(swp_s4[j]), 7'd26));

			// projection times axis
			it_s6 <= it_s5;
			t1_s6 <= t1_s5;
			t2_s6 <= t2_s5;
			for (int j = 0; j < 3; j++) ku_s6[j] <= 69'(k_s5) * 69'(u_s5[j]);

			it_s7 <= it_s6;
			for (int j = 0; j < 3; j++) begin
				t3_s7[j] <= 40'(round_off(72'(ku_s6[j]), 7'd26));
				t12_s7[j] <= 39'(t1_s6[j]) + 39'(t2_s6[j]);
			end

			it_s8 <= it_s7;
			for (int j = 0; j < 3; j++) sum_s8[j] <= 42'(t12_s7[j]) + 42'(t3_s7[j]);

			// result register, zero axis passes the vector
			word_s9.last_out <= it_s8.last;
			word_s9.zero_axis <= it_s8.zero;
			word_s9.out_x <= it_s8.zero ? $signed(it_s8.v[0]) : sat[0];
			word_s9.out_y <= it_s8.zero ? $signed(it_s8.v[1]) : sat[1];
			word_s9.out_z <= it_s8.zero ? $signed(it_s8.v[2]) : sat[2];
		end
	end

	assign vld_out = vld_s9;
	assign word_out = word_s9;

endmodule

[hdl/rodrigues_vector_rotator_unit.sv]
// Rodrigues vector rotator: rotates Q16.16 3-vectors about an axis by a binary angle
// depends on rvr_pkg, rvr_if, rvr_front, rvr_cordic, rvr_norm, rvr_back
//
// Usage:
//   vectors: input words (vector, angle, axis, last flag), valid/ready.
//   results: rotated vector, copied last flag and zero-axis flag, valid/ready.
//   cfg:     register writes (index, data); always ready, writes land at once.
//            Registers choose per-word or shared angle and axis, and hold the
//            shared angle and axis. Write them only while the pipeline is empty.
// Throughput: one word per cycle, sustained, when results are taken.
// Pipeline: the CORDIC chain, the 32-stage square root and the 31-stage divider
//   lie all in series.
// Reset: clears all valid bits and loads the register defaults (per-word angle
//   and axis, shared angle zero, shared axis +x).
// Stall: when a result is held, every stage freezes together and vectors.ready
//   drops; an empty result register never blocks the input.
// Zero-length axis: the vector passes through unchanged with zero_axis set.
module rodrigues_vector_rotator_unit #(
	parameter int CORDIC_STAGES = rvr_pkg::CORDIC_STAGES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	rvr_cfg_if.sink  cfg,
	rvr_in_if.sink   vectors,
	rvr_out_if.source results
);
	import rvr_pkg::*;

	logic       en;
	cfg_state_t cfg_q;
	logic       fr_vld, cd_vld, nm_vld;
	item_t      fr_item, cd_item, nm_item;

	// whole pipeline moves unless a result is held
	assign en = !results.valid || results.ready;
	assign vectors.ready = en;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_per_item <= 1'b1;
			cfg_q.axis_per_item <= 1'b1;
			cfg_q.shared_angle <= '0;
			cfg_q.shared_axis[0] <= 32'd65536;
			cfg_q.shared_axis[1] <= '0;
			cfg_q.shared_axis[2] <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ANGLE_PER_ITEM: cfg_q.angle_per_item <= cfg.data[0];
				REG_AXIS_PER_ITEM:  cfg_q.axis_per_item <= cfg.data[0];
				REG_SHARED_ANGLE:   cfg_q.shared_angle <= cfg.data;
				REG_SHARED_AXIS_X:  cfg_q.shared_axis[0] <= cfg.data;
				REG_SHARED_AXIS_Y:  cfg_q.shared_axis[1] <= cfg.data;
				REG_SHARED_AXIS_Z:  cfg_q.shared_axis[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	rvr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vectors.valid),
		.word     (vectors.data),
		.cfgs     (cfg_q),
		.vld_out  (fr_vld),
		.item_out (fr_item)
	);

	rvr_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (fr_vld),
		.item_in  (fr_item),
		.vld_out  (cd_vld),
		.item_out (cd_item)
	);

	rvr_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (cd_vld),
		.item_in  (cd_item),
		.vld_out  (nm_vld),
		.item_out (nm_item)
	);

	rvr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (nm_vld),
		.item_in  (nm_item),
		.vld_out  (results.valid),
		.word_out (results.data)
	);

`ifndef SYNTHESIS
	// a held result blocks new words
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |-> !vectors.ready)
		else $error("word accepted while result held");

	// an empty result register never blocks input
	a_empty_flows: assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> vectors.ready)
		else $error("input blocked with empty result register");

	// a held result stays valid with the same flags
	a_hold_flags: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid
		&& $stable(results.data.zero_axis) && $stable(results.data.last_out))
		else $error("held result changed");
`endif

endmodule

[sim/testbench.sv]
// testbench: directed and randomized check of the Rodrigues vector rotator against an in-bench predictor
// depends on rvr_pkg, rvr_if and rodrigues_vector_rotator_unit
`timescale 1ns / 100ps

module testbench;
	import rvr_pkg::*;

	localparam int PIPE_DRAIN = 150;
	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam logic [2:0] REG_TOP_INDEX = 3'd7;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	// arctangent table for the predictor's own cordic
	localparam longint ARCTAN [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5339221, 2669139, 1334575, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0
	};

	// keeps the register shadow, predicts rotated words and checks results
	class rotation_scoreboard;
		bit             angle_sel;
		bit             axis_sel;
		logic [31:0]    bcast_angle;
		logic [31:0]    bcast_axis [3];
		out_word_t      pending_q [$];
		int             mismatches;
		int             checked;
		int             zero_seen;

		function new();
			angle_sel = 1;
			axis_sel = 1;
			bcast_angle = 0;
			bcast_axis[0] = 32'd65536;
			bcast_axis[1] = 0;
			bcast_axis[2] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_ANGLE_PER_ITEM: angle_sel = val[0];
				REG_AXIS_PER_ITEM:  axis_sel = val[0];
				REG_SHARED_ANGLE:   bcast_angle = val;
				REG_SHARED_AXIS_X:  bcast_axis[0] = val;
				REG_SHARED_AXIS_Y:  bcast_axis[1] = val;
				REG_SHARED_AXIS_Z:  bcast_axis[2] = val;
				default: ;
			endcase
		endfunction

		function longint unsigned magn(longint v);
			return v < 0 ? longint'(-v) : longint'(v);
		endfunction

		function longint rnd_shift(longint v, int sh);
			longint unsigned r;
			r = (magn(v) + (64'd1 << (sh - 1))) >> sh;
			return v < 0 ? -longint'(r) : longint'(r);
		endfunction

		function longint mul_rnd(longint a, longint b, int sh);
			longint unsigned r;
			r = (magn(a) * magn(b) + (64'd1 << (sh - 1))) >> sh;
			return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// cordic sine and cosine in q2.30, quadrant folded back at the end
		function void sin_cos(logic [31:0] ang, output longint c, output longint s);
			logic [31:0] t;
			longint x, y, z, nx;
			t = ang + 32'h2000_0000;
			z = longint'({2'b00, t[29:0]}) - 64'sd536870912;
			x = 652032874;
			y = 0;
			for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= ARCTAN[i];
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += ARCTAN[i];
				end
				x = nx;
			end
			if (x > ONE_Q30) x = ONE_Q30;
			if (x < -ONE_Q30) x = -ONE_Q30;
			if (y > ONE_Q30) y = ONE_Q30;
			if (y < -ONE_Q30) y = -ONE_Q30;
			case (t[31:30])
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		function out_word_t rotate(in_word_t w);
			out_word_t o;
			longint v [3], a [3], b [3], u [3], cr [3];
			longint c, s, p, p16, k, sum;
			longint unsigned m, norm2, nrm, q;
			logic [31:0] ang;
			int sh;
			v[0] = longint'($signed(w.vec_x));
			v[1] = longint'($signed(w.vec_y));
			v[2] = longint'($signed(w.vec_z));
			ang = angle_sel ? w.angle : bcast_angle;
			if (axis_sel) begin
				a[0] = longint'($signed(w.axis_x));
				a[1] = longint'($signed(w.axis_y));
				a[2] = longint'($signed(w.axis_z));
			end else begin
				for (int j = 0; j < 3; j++) a[j] = longint'($signed(bcast_axis[j]));
			end
			o.last_out = w.last_in;
			m = 0;
			for (int j = 0; j < 3; j++) if (magn(a[j]) > m) m = magn(a[j]);
			if (m == 0) begin
				o.out_x = w.vec_x;
				o.out_y = w.vec_y;
				o.out_z = w.vec_z;
				o.zero_axis = 1;
				return o;
			end
			o.zero_axis = 0;
			// normalize the axis to unit length in q2.30
			sh = 0;
			while (m < (64'd1 << 30)) begin
				m <<= 1;
				sh++;
			end
			norm2 = 0;
			for (int j = 0; j < 3; j++) begin
				b[j] = a[j] <<< sh;
				norm2 += magn(b[j]) * magn(b[j]);
			end
			nrm = int_sqrt(norm2);
			for (int j = 0; j < 3; j++) begin
				q = ((magn(b[j]) << 30) + (nrm >> 1)) / nrm;
				u[j] = b[j] < 0 ? -longint'(q) : longint'(q);
			end
			sin_cos(ang, c, s);
			// cross and dot products, then the three terms per component
			p = 0;
			for (int j = 0; j < 3; j++) begin
				cr[j] = rnd_shift(u[(j + 1) % 3] * v[(j + 2) % 3]
					- u[(j + 2) % 3] * v[(j + 1) % 3], 30);
				p += u[j] * v[j];
			end
			p16 = rnd_shift(p, 30);
			k = mul_rnd(ONE_Q30 - c, p16, 30);
			for (int j = 0; j < 3; j++) begin
				sum = rnd_shift(mul_rnd(c, v[j], 26) + mul_rnd(s, cr[j], 26)
					+ mul_rnd(k, u[j], 26), 4);
				if (sum > 64'sd2147483647) sum = 64'sd2147483647;
				if (sum < -64'sd2147483648) sum = -64'sd2147483648;
				case (j)
					0: o.out_x = sum[31:0];
					1: o.out_y = sum[31:0];
					default: o.out_z = sum[31:0];
				endcase
			end
			return o;
		endfunction

		function void note_input(in_word_t w);
			pending_q.push_back(rotate(w));
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_w;
			checked++;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h with nothing pending", got);
				return;
			end
			exp_w = pending_q.pop_front();
			if (exp_w.zero_axis) zero_seen++;
			if (got !== exp_w) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch #%0d: exp x=%0d y=%0d z=%0d l=%b z=%b, got x=%0d y=%0d z=%0d l=%b z=%b",
						checked, exp_w.out_x, exp_w.out_y, exp_w.out_z, exp_w.last_out,
						exp_w.zero_axis, got.out_x, got.out_y, got.out_z, got.last_out,
						got.zero_axis);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   sent;

	rvr_cfg_if cfg_bus ();
	rvr_in_if  vec_bus ();
	rvr_out_if res_bus ();

	rotation_scoreboard sb;

	rodrigues_vector_rotator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus.sink),
		.vectors(vec_bus.sink),
		.results(res_bus.source)
	);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// register write, waits for the handshake; the caller drops valid after the last one
	task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
		logic hs;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		cfg_bus.valid <= 1;
		do begin
			@(negedge clk);
			hs = cfg_bus.ready;
			@(posedge clk);
		end while (!hs);
		sb.write_reg(idx, val);
	endtask

	// send one word after a random gap when idle_on is set; valid stays high when the gap is zero
	task automatic send_word(in_word_t w);
		int gap;
		logic hs;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			vec_bus.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		vec_bus.data <= w;
		vec_bus.valid <= 1;
		do begin
			@(negedge clk);
			hs = vec_bus.ready;
			@(posedge clk);
		end while (!hs);
		sb.note_input(w);
		sent++;
	endtask

	task automatic wait_drain();
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 0;
			3: return $urandom_range(0, 3) - 1;
			4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			5: return 32'($signed(20'($urandom))) <<< 12;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return {3'($urandom_range(0, 7)), 29'd0};
			1: return {3'($urandom_range(0, 7)), 29'd0} + $urandom_range(0, 4) - 2;
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w.vec_x = rand_comp();
		w.vec_y = rand_comp();
		w.vec_z = rand_comp();
		w.angle = rand_angle();
		case ($urandom_range(0, 9))
			0: begin w.axis_x = 0; w.axis_y = 0; w.axis_z = 0; end
			1: begin
				w.axis_x = 0; w.axis_y = 0; w.axis_z = 0;
				case ($urandom_range(0, 2))
					0: w.axis_x = rand_comp();
					1: w.axis_y = rand_comp();
					default: w.axis_z = rand_comp();
				endcase
			end
			default: begin
				w.axis_x = rand_comp();
				w.axis_y = rand_comp();
				w.axis_z = rand_comp();
			end
		endcase
		w.last_in = 1'($urandom_range(0, 1));
		return w;
	endfunction

	function automatic in_word_t make_word(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
		logic [31:0] ang, logic [31:0] ax, logic [31:0] ay, logic [31:0] az, logic lst);
		in_word_t w;
		w.vec_x = vx; w.vec_y = vy; w.vec_z = vz; w.angle = ang;
		w.axis_x = ax; w.axis_y = ay; w.axis_z = az; w.last_in = lst;
		return w;
	endfunction

	// result side: random stalls when idle_on is set, check each accepted word
	initial begin
		int stall;
		logic hs;
		out_word_t got;
		res_bus.ready = 0;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				res_bus.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1;
			do begin
				@(negedge clk);
				hs = res_bus.valid && res_bus.ready;
				got = res_bus.data;
				@(posedge clk);
			end while (!hs);
			sb.check_result(got);
		end
	end

	// stimulus
	initial begin
		logic [31:0] mx, mn;
		sb = new();
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		arst_n = 0;
		idle_on = 0;
		sent = 0;
		cfg_bus.valid = 0;
		cfg_bus.index = REG_ANGLE_PER_ITEM;
		cfg_bus.data = 0;
		vec_bus.valid = 0;
		vec_bus.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, quadrant edges, zero and tiny axes
		send_word(make_word(32'h0001_0000, 0, 0, 32'h4000_0000, 0, 0, 32'h0001_0000, 1));
		send_word(make_word(mx, mx, mx, 0, 32'h0001_0000, 0, 0, 0));
		send_word(make_word(mn, mn, mn, 32'h8000_0000, 0, 32'h0001_0000, 0, 1));
		send_word(make_word(mx, mn, mx, 32'hC000_0000, mn, mn, mn, 0));
		send_word(make_word(mn, mx, mn, 32'hFFFF_FFFF, mx, mx, mx, 1));
		send_word(make_word(32'h1234_5678, mx, mn, 32'h2000_0000, 0, 0, 0, 1));
		send_word(make_word(mx, mx, mx, 32'h6000_0000, 0, 0, 0, 0));
		send_word(make_word(mn, mx, 1, 32'hA000_0000, 1, 0, 0, 0));
		send_word(make_word(mx, mx, mx, 32'hE000_0000, 1, 1, 1, 1));
		send_word(make_word(mn, mn, mn, 32'h1FFF_FFFF, mn, 0, 0, 0));
		send_word(make_word(mx, mn, 0, 32'h5555_5555, mx, mn, 1, 1));
		send_word(make_word(32'hFFFF_FFFF, 1, 0, 32'h4000_0000, 0, 0, 32'hFFFF_FFFF, 0));
		send_word(make_word(mx, mx, mx, 32'h8000_0000, mx, mx, mx, 0));
		send_word(make_word(0, 0, 0, $urandom, $urandom, $urandom, $urandom, 1));
		send_word(make_word(mx, 0, mn, 32'h3FFF_FFFF, 0, mx, 0, 0));
		vec_bus.valid <= 0;
		wait_drain();

		// random phases across register settings
		for (int ph = 0; ph < 9; ph++) begin
			idle_on = (ph % 3) != 0;
			case (ph)
				1: begin
					write_cfg(REG_ANGLE_PER_ITEM, 0);
					write_cfg(REG_SHARED_ANGLE, 32'hFFFF_FFFF);
				end
				2: begin
					write_cfg(REG_AXIS_PER_ITEM, 32'hFFFF_FFFE);
					write_cfg(REG_SHARED_AXIS_X, mn);
					write_cfg(REG_SHARED_AXIS_Y, mn);
					write_cfg(REG_SHARED_AXIS_Z, mn);
					write_cfg(REG_SHARED_ANGLE, 32'h4000_0000);
				end
				3: begin
					write_cfg(REG_ANGLE_PER_ITEM, 1);
					write_cfg(REG_SHARED_AXIS_X, 0);
					write_cfg(REG_SHARED_AXIS_Y, 0);
					write_cfg(REG_SHARED_AXIS_Z, 0);
				end
				4: begin
					write_cfg(REG_SHARED_AXIS_Z, mx);
					write_cfg(REG_SHARED_AXIS_X, mx);
					write_cfg(REG_UNUSED, 32'hDEAD_BEEF);
					write_cfg(REG_TOP_INDEX, 0);
				end
				5: begin
					write_cfg(REG_ANGLE_PER_ITEM, 0);
					write_cfg(REG_SHARED_ANGLE, 0);
					write_cfg(REG_SHARED_AXIS_X, $urandom);
					write_cfg(REG_SHARED_AXIS_Y, $urandom);
					write_cfg(REG_SHARED_AXIS_Z, 1);
				end
				6: begin
					write_cfg(REG_AXIS_PER_ITEM, 1);
					write_cfg(REG_SHARED_ANGLE, $urandom);
				end
				7: begin
					write_cfg(REG_ANGLE_PER_ITEM, 1);
					write_cfg(REG_AXIS_PER_ITEM, 0);
					write_cfg(REG_SHARED_AXIS_X, 32'h0000_0001);
					write_cfg(REG_SHARED_AXIS_Y, 32'hFFFF_FFFF);
					write_cfg(REG_SHARED_AXIS_Z, 0);
				end
				8: write_cfg(REG_AXIS_PER_ITEM, 1);
				default: ;
			endcase
			// end of the register burst
			cfg_bus.valid <= 0;
			repeat (180) send_word(rand_word());
			vec_bus.valid <= 0;
			wait_drain();
		end
	end

	// end of run once all words are back
	initial begin
		@(posedge arst_n);
		wait (sent >= 1635);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		$display("sent %0d words, checked %0d results (%0d with a zero axis)",
			sent, sb.checked, sb.zero_seen);
		$display("%0d mismatches, %0d results still pending",
			sb.mismatches, sb.pending_q.size());
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("timeout after %0d words sent", sent);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
